/* rtl/hcbp_pkg.sv */
// ---------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Command codes, field widths and the request format that the front part
// hands to the back part through the queue.
// ---------------------------------------------------------------------------
package hcbp_pkg;

  // Field widths fixed by the stream format
  localparam int CMD_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 9;

  // Bit accumulator: up to 7 pending bits plus one full-length code
  localparam int ACC_W = 40;
  localparam int CNT_W = 6;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [FILL_W-1:0] FILL_MAX = 9'd511;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // Request passed from front to back
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

/* rtl/hcbp_front.sv */
// ---------------------------------------------------------------------------
// hcbp_front: request intake and code table
// Accepts requests, writes table entries on loads, looks up the code of each
// encoded symbol and forwards encode and flush requests to the queue.
// ---------------------------------------------------------------------------
module hcbp_front #(
  parameter int MAX_CODE_BITS = 32,
  parameter int SYMBOL_COUNT  = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hcbp_pkg::CMD_W-1:0]       cmd,
  input  logic [hcbp_pkg::SYM_IN_W-1:0]    symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]      code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]       code_length,
  output logic                             push,
  output hcbp_pkg::item_t                  push_item,
  input  logic                             q_full
);
  import hcbp_pkg::*;

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W);

  logic [CODE_W+LEN_W-1:0] code_mem [0:SYMBOL_COUNT-1];
  logic [CODE_W+LEN_W-1:0] rd_entry;
  logic                    s1_valid;
  logic                    s1_flush;

  logic                    accept;
  logic                    sym_ok;
  logic                    is_load;
  logic                    is_enc;
  logic                    is_flush;
  logic [SYM_W-1:0]        idx;
  logic [LEN_W-1:0]        cap_len;
  logic [CODE_W-1:0]       len_mask;

  // Decode the request
  assign accept   = in_valid && !in_stall;
  assign sym_ok   = {1'b0, symbol} < 9'(SYMBOL_COUNT);
  assign is_load  = (cmd == CMD_LOAD);
  assign is_enc   = (cmd == CMD_ENCODE);
  assign is_flush = (cmd == CMD_FLUSH);
  assign idx      = symbol[SYM_W-1:0];

  // Hold intake while the lookup stage cannot drain
  assign in_stall = s1_valid && q_full;
  assign push     = s1_valid && !q_full;

  // Saturate the length and clear code bits above it
  always_comb begin
    cap_len = (code_length > LEN_CAP) ? LEN_CAP : code_length;
    for (int i = 0; i < CODE_W; i++) begin
      len_mask[i] = (LEN_W'(i) < cap_len);
    end
  end

  // Code table: write on load, registered read on encode
  always_ff @(posedge clk) begin
    if (accept && is_load && sym_ok) begin
      code_mem[idx] <= {code_bits & len_mask, cap_len};
    end
    if (accept && is_enc && sym_ok) begin
      rd_entry <= code_mem[idx];
    end
  end

  // Lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (accept) begin
      s1_valid <= (is_enc && sym_ok) || is_flush;
      s1_flush <= is_flush;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // Forward the request with its code
  always_comb begin
    push_item.is_flush = s1_flush;
    push_item.code     = rd_entry[CODE_W+LEN_W-1:LEN_W];
    push_item.len      = rd_entry[LEN_W-1:0];
  end

endmodule

/* rtl/hcbp_queue.sv */
// ---------------------------------------------------------------------------
// hcbp_queue: request queue between front and back
// A short first-in first-out buffer that lets each side stall on its own.
// ---------------------------------------------------------------------------
module hcbp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hcbp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output hcbp_pkg::item_t head_item
);
  import hcbp_pkg::*;

  item_t              slots [0:QDEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/hcbp_back.sv */
// ---------------------------------------------------------------------------
// hcbp_back: bit packer and result register
// Merges codes into the bit accumulator, emits one full byte per cycle
// unless stalled, and builds the end-of-stream result and block fill count.
// ---------------------------------------------------------------------------
module hcbp_back #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  hcbp_pkg::item_t                head_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]    data_byte,
  output logic                           byte_valid,
  output logic [hcbp_pkg::FILL_W-1:0]    zero_fill_count,
  output logic                           last
);
  import hcbp_pkg::*;

  localparam int OW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int FW = OW + 1;
  localparam int BW = (FW > FILL_W) ? FW : FILL_W;
  localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(BYTE_W);
  localparam logic [CNT_W-1:0] ACC_MAX   = CNT_W'(ACC_W - 1);

  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  nbits;
  logic [OW-1:0]     offset;
  logic              seen;

  logic [ACC_W-1:0]  acc_sh;
  logic [CNT_W-1:0]  n_sh;
  logic [ACC_W-1:0]  acc_next;
  logic [CNT_W-1:0]  n_next;
  logic [OW-1:0]     offset_inc;
  logic [OW-1:0]     off_end;
  logic [FW-1:0]     fill_raw;
  logic [BW-1:0]     fill_big;
  logic              out_free;
  logic              emit;
  logic              take_enc;
  logic              take_flush;
  logic              part_valid;
  logic [BYTE_W-1:0] flush_byte;
  logic [FILL_W-1:0] flush_fill;

  // Drain one byte when the result register is free
  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free && (nbits >= BYTE_BITS);
  assign acc_sh   = emit ? (acc >> BYTE_W) : acc;
  assign n_sh     = emit ? (nbits - BYTE_BITS) : nbits;

  // Take the next request once fewer than a byte of bits remain
  assign take_enc   = head_valid && !head_item.is_flush && (n_sh < BYTE_BITS);
  assign take_flush = head_valid && head_item.is_flush && (nbits < BYTE_BITS)
                      && out_free;
  assign pop        = take_enc || take_flush;

  // Merge the code above the pending bits
  always_comb begin
    acc_next = acc_sh;
    n_next   = n_sh;
    if (take_enc) begin
      acc_next = acc_sh | ({{(ACC_W-CODE_W){1'b0}}, head_item.code} << n_sh[2:0]);
      n_next   = n_sh + head_item.len;
    end
  end

  // Block offset and fill count for the final result
  always_comb begin
    offset_inc = (offset == OW'(BLOCK_BYTES - 1)) ? '0 : (offset + 1'b1);
    part_valid = seen && (nbits != '0);
    off_end    = part_valid ? offset_inc : offset;
    fill_raw   = (off_end == '0) ? '0 : (FW'(BLOCK_BYTES) - {1'b0, off_end});
    fill_big   = BW'(fill_raw);
    flush_fill = '0;
    if (seen) begin
      flush_fill = (fill_big > BW'(FILL_MAX)) ? FILL_MAX : FILL_W'(fill_big);
    end
    flush_byte = part_valid ? acc[BYTE_W-1:0] : '0;
  end

  // Accumulator and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      nbits  <= '0;
      offset <= '0;
      seen   <= 1'b0;
    end else if (take_flush) begin
      acc    <= '0;
      nbits  <= '0;
      offset <= '0;
      seen   <= 1'b0;
    end else begin
      acc   <= acc_next;
      nbits <= n_next;
      if (emit) begin
        offset <= offset_inc;
      end
      if (take_enc) begin
        seen <= 1'b1;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit || take_flush;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      data_byte       <= acc[BYTE_W-1:0];
      byte_valid      <= 1'b1;
      zero_fill_count <= '0;
      last            <= 1'b0;
    end else if (take_flush) begin
      data_byte       <= flush_byte;
      byte_valid      <= part_valid;
      zero_fill_count <= flush_fill;
      last            <= 1'b1;
    end
  end

  // Accumulator never holds more bits than it has room for
  assert property (@(posedge clk) disable iff (rst) nbits <= ACC_MAX)
    else $error("bit count beyond accumulator");

  // A byte and a stream end never load the result register together
  assert property (@(posedge clk) disable iff (rst) !(emit && take_flush))
    else $error("byte and flush result in the same cycle");

  // A flush leaves the stream empty
  assert property (@(posedge clk) disable iff (rst)
    take_flush |=> (nbits == '0) && !seen && (offset == '0))
    else $error("stream state not cleared after flush");

endmodule

/* rtl/huffman_code_bit_packer.sv */
// ---------------------------------------------------------------------------
// huffman_code_bit_packer: Huffman encoder with byte packing
// Loads a table of variable-length codes and packs encoded symbols into
// bytes, first code bit in bit 0, with end-of-stream block padding count.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle when
//   not stalled: table load (cmd 0), symbol to encode (cmd 1), flush (cmd 2).
//   Output channel (out_valid / out_stall) returns packed bytes and, for a
//   flush, one final result with last set and the zero fill count.
// Path: an encode goes through the table read register, the queue and the
//   accumulator into the result register; a flush result follows owed bytes.
// Throughput: one request per cycle while encodes complete at most one byte
//   each and out_stall is low; the packer sends one byte per cycle when not
//   stalled, so an encode completing k bytes occupies it until all are sent.
//   A four-entry queue between table lookup and packer absorbs these bursts.
// Reset: the stream state is cleared; the code table holds whatever was
//   loaded, and entries never loaded must not be encoded.
// Stall: while out_stall is high a valid result holds; the queue fills
//   and then in_stall rises until the packer drains again.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer #(
  parameter int MAX_CODE_BITS = 32,
  parameter int BLOCK_BYTES   = 512,
  parameter int SYMBOL_COUNT  = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hcbp_pkg::CMD_W-1:0]    cmd,
  input  logic [hcbp_pkg::SYM_IN_W-1:0] symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]   data_byte,
  output logic                          byte_valid,
  output logic [hcbp_pkg::FILL_W-1:0]   zero_fill_count,
  output logic                          last
);
  import hcbp_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  // Intake and table lookup
  hcbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_COUNT  (SYMBOL_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  // Decoupling queue
  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Bit packing and results
  hcbp_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .zero_fill_count (zero_fill_count),
    .last            (last)
  );

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for huffman_code_bit_packer
// Loads code table entries, encodes symbol runs and flushes streams through
// the valid/stall request channel. A scoreboard predicts every packed byte
// and flush result and checks them in order on the result channel. Idling
// phases vary sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import hcbp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int PAD_BLOCK     = 512;
  localparam int RANDOM_ITEMS  = 330;
  localparam int BOUNDARY_RUN  = 128;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic [FILL_W-1:0] fill;
    logic              last;
  } packer_result_t;

  // Predicts packed bytes and flush results and checks them in order
  class stream_scoreboard;
    logic [CODE_W-1:0] code_mem [256];
    logic [LEN_W-1:0]  len_mem  [256];
    logic [BYTE_W-1:0] partial_byte;
    logic [2:0]        partial_bits;
    logic [FILL_W-1:0] block_offset;
    bit                stream_started;
    packer_result_t    owed_results [$];
    int                errors;
    int                bytes_checked;
    int                ends_checked;
    int                requests_noted;

    function new();
      clear_stream();
      errors         = 0;
      bytes_checked  = 0;
      ends_checked   = 0;
      requests_noted = 0;
    endfunction

    function void clear_stream();
      partial_byte   = '0;
      partial_bits   = '0;
      block_offset   = '0;
      stream_started = 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] op, logic [SYM_IN_W-1:0] sym,
                               logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len);
      logic [ACC_W-1:0]  acc;
      logic [LEN_W-1:0]  cut;
      logic [FILL_W-1:0] off;
      packer_result_t    res;
      int                nbits;
      int                fill;
      requests_noted++;
      case (op)
        CMD_LOAD: begin
          // Saturate the length and clear code bits above it
          cut = (len > 6'd32) ? 6'd32 : len;
          len_mem[sym]  = cut;
          code_mem[sym] = (cut == 6'd32) ? bits : (bits & ((32'd1 << cut) - 32'd1));
        end
        CMD_ENCODE: begin
          stream_started = 1;
          acc   = ACC_W'(partial_byte) | (ACC_W'(code_mem[sym]) << partial_bits);
          nbits = int'(partial_bits) + int'(len_mem[sym]);
          // Emit each completed byte
          while (nbits >= 8) begin
            res       = '0;
            res.data  = acc[7:0];
            res.valid = 1'b1;
            owed_results.push_back(res);
            acc   = acc >> 8;
            nbits = nbits - 8;
            block_offset = block_offset + 1'b1;
          end
          partial_byte = acc[7:0];
          partial_bits = nbits[2:0];
        end
        CMD_FLUSH: begin
          res      = '0;
          res.last = 1'b1;
          if (stream_started) begin
            off = block_offset;
            if (partial_bits != 0) begin
              res.data  = partial_byte & ((8'd1 << partial_bits) - 8'd1);
              res.valid = 1'b1;
              off = off + 1'b1;
            end
            fill = (PAD_BLOCK - int'(off)) % PAD_BLOCK;
            if (fill > int'(FILL_MAX)) fill = int'(FILL_MAX);
            res.fill = fill[FILL_W-1:0];
          end
          owed_results.push_back(res);
          clear_stream();
        end
        default: ;
      endcase
    endfunction

    function void check_result(packer_result_t got);
      packer_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual data_byte=%h byte_valid=%b fill=%0d last=%b",
                 $time, got.data, got.valid, got.fill, got.last);
        return;
      end
      want = owed_results.pop_front();
      if (want.last) ends_checked++;
      else bytes_checked++;
      if (got.data !== want.data || got.valid !== want.valid ||
          got.fill !== want.fill || got.last !== want.last) begin
        errors++;
        $display("%0t: mismatch expected data_byte=%h byte_valid=%b fill=%0d last=%b,",
                 $time, want.data, want.valid, want.fill, want.last,
                 " actual data_byte=%h byte_valid=%b fill=%0d last=%b",
                 got.data, got.valid, got.fill, got.last);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd = '0;
  logic [SYM_IN_W-1:0] symbol = '0;
  logic [CODE_W-1:0]   code_bits = '0;
  logic [LEN_W-1:0]    code_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   data_byte;
  logic                byte_valid;
  logic [FILL_W-1:0]   zero_fill_count;
  logic                last;

  stream_scoreboard pack_sb;
  packer_result_t   seen_result;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               cycle_count = 0;
  int               random_sent = 0;
  bit               is_loaded [256];
  int               loaded_syms [$];

  huffman_code_bit_packer u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .symbol          (symbol),
    .code_bits       (code_bits),
    .code_length     (code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .zero_fill_count (zero_fill_count),
    .last            (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, pack_sb.owed_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Take results and drive random stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen_result.data  = data_byte;
        seen_result.valid = byte_valid;
        seen_result.fill  = zero_fill_count;
        seen_result.last  = last;
        pack_sb.check_result(seen_result);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [SYM_IN_W-1:0] sym,
                              input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    symbol      <= sym;
    code_bits   <= bits;
    code_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_sb.note_request(op, sym, bits, len);
    if (op != CMD_UNKNOWN) random_sent++;
  endtask

  task automatic load_entry(input logic [SYM_IN_W-1:0] sym, input logic [CODE_W-1:0] bits,
                            input logic [LEN_W-1:0] len);
    send_request(CMD_LOAD, sym, bits, len);
    if (!is_loaded[sym]) begin
      is_loaded[sym] = 1;
      loaded_syms.push_back(int'(sym));
    end
  endtask

  // Mostly short codes, with empty, full and over-long lengths mixed in
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(7))
      0:       return LEN_W'($urandom_range(33, 63));
      1:       return '0;
      2:       return 6'd32;
      default: return LEN_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic encode_any();
    send_request(CMD_ENCODE, SYM_IN_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]),
                 $urandom, LEN_W'($urandom));
  endtask

  initial begin
    int n_loads;
    int n_enc;
    bit boundary_done;
    pack_sb = new();
    boundary_done = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stream, zero-length codes, saturated lengths, masked bits
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    load_entry(8'd0, 32'hFFFF_FFFF, 6'd0);
    send_request(CMD_ENCODE, 8'd0, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    load_entry(8'd255, 32'hFFFF_FFFF, 6'd63);
    load_entry(8'd1, 32'hFFFF_FFFE, 6'd1);
    load_entry(8'd2, 32'h0000_0055, 6'd7);
    load_entry(8'd3, 32'hFFFF_FFA5, 6'd8);
    load_entry(8'd128, 32'h8000_0001, 6'd33);
    load_entry(8'd170, 32'h2AAA_AAAA, 6'd20);
    load_entry(8'd85, 32'h0000_0003, 6'd2);
    send_request(CMD_ENCODE, 8'd255, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd1, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd2, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd170, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd85, 32'd0, 6'd0);
    send_request(CMD_UNKNOWN, 8'd255, 32'hFFFF_FFFF, 6'd63);
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    // Whole byte only, so the flush has no partial byte
    send_request(CMD_ENCODE, 8'd3, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd128, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd1, 32'd0, 6'd0);
    send_request(CMD_ENCODE, 8'd0, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);

    // Random streams across the idling phases
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (random_sent * 4 / RANDOM_ITEMS)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase

      // One stream that ends exactly on a block boundary
      if (!boundary_done && random_sent >= RANDOM_ITEMS / 3) begin
        boundary_done = 1;
        send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        load_entry(8'd255, $urandom, 6'd32);
        repeat (BOUNDARY_RUN) send_request(CMD_ENCODE, 8'd255, 32'd0, 6'd0);
        send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        continue;
      end

      n_loads = $urandom_range(3);
      repeat (n_loads) load_entry(SYM_IN_W'($urandom), $urandom, pick_length());
      n_enc = $urandom_range(1, 24);
      repeat (n_enc) begin
        case ($urandom_range(15))
          0:       send_request(CMD_UNKNOWN, SYM_IN_W'($urandom), $urandom, LEN_W'($urandom));
          1:       load_entry(SYM_IN_W'($urandom), $urandom, pick_length());
          default: encode_any();
        endcase
      end
      // Mostly end the stream; sometimes let it run on or flush twice
      case ($urandom_range(19))
        0, 1:    ;
        2:       repeat (2) send_request(CMD_FLUSH, SYM_IN_W'($urandom), $urandom,
                                         LEN_W'($urandom));
        default: send_request(CMD_FLUSH, SYM_IN_W'($urandom), $urandom, LEN_W'($urandom));
      endcase
    end
    send_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    in_valid  <= 1'b0;
    stall_pct = 0;

    // Drain owed results, then watch for strays
    while (pack_sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d packed bytes and %0d stream ends checked",
             pack_sb.requests_noted, pack_sb.bytes_checked, pack_sb.ends_checked);
    $display("Idling phases: none, sender gaps, receiver stalls, both; %0d errors",
             pack_sb.errors);
    if (pack_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hcbp_pkg.sv
rtl/hcbp_front.sv
rtl/hcbp_queue.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer.sv
tb/testbench.sv
